/* sv/pclte_pkg.sv */
// Package with the shared constants and types of the pc/line table encoder.
`timescale 1ns / 1ps
package pclte_pkg;

   localparam int MIN_INSTR_BYTES_DEF = 4;
   localparam int MAX_UNITS           = 7493;
   localparam int UNITS_PER_BYTE      = 127;
   localparam int ADV_BASE            = 128;
   localparam int PAD_BYTE            = 129;
   localparam int DOWN_BASE           = 64;
   localparam int LONG_MARK           = 0;
   localparam int RECIP_SHIFT         = 16;

   typedef struct packed {
      logic       big;
      logic [6:0] units;
   } adv_stat_type;

endpackage

/* sv/pclte_if.sv */
// Handshake interfaces of the request and response channels.
`timescale 1ns / 1ps
interface pclte_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] pc;
   logic [30:0] line;
   logic        skip;

   modport source (output valid, func, pc, line, skip, input ready);
   modport sink (input valid, func, pc, line, skip, output ready);
endinterface

interface pclte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       overflow;

   modport source (output valid, out_byte, last, overflow, input ready);
   modport sink (input valid, out_byte, last, overflow, output ready);
endinterface

/* sv/pclte_adv_unit.sv */
// Shared subtract and divide unit that splits an address advance into table bytes.
`timescale 1ns / 1ps
module pclte_adv_unit
   import pclte_pkg::*;
#(
   parameter int MIN_INSTR_BYTES = MIN_INSTR_BYTES_DEF,
   parameter int REM_W = 16
) (
   input  logic             clock,
   input  logic             load,
   input  logic [REM_W-1:0] load_val,
   input  logic             step,
   output adv_stat_type     stat
);

   localparam int STEP_BYTES = UNITS_PER_BYTE * MIN_INSTR_BYTES;
   localparam int RECIP = ((1 << RECIP_SHIFT) + MIN_INSTR_BYTES - 1) / MIN_INSTR_BYTES;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int PROD_W = REM_W + RECIP_W;

   logic [REM_W-1:0]   rem_ff;
   logic [REM_W-1:0]   rem_in;
   logic [PROD_W-1:0]  prod;

   always_comb begin
      rem_in = rem_ff;
      if (load) begin
         rem_in = load_val;
      end else if (step) begin
         rem_in = rem_ff - REM_W'(STEP_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   // The remainder is below one full byte of units here, so the scaled reciprocal is exact.
   assign prod = PROD_W'(rem_ff) * PROD_W'(RECIP);
   assign stat.big = (rem_ff >= REM_W'(STEP_BYTES));
   assign stat.units = prod[RECIP_SHIFT +: 7];

endmodule

/* sv/pc_line_table_encoder.sv */
// Top level of the pc/line delta table encoder.
//
// Requests arrive on req_ch: either an instruction record (address, source line, skip
// mark) or an end-of-table item. Table bytes leave on rsp_ch, one byte per transfer,
// with last set on the final byte caused by a request. A record that is skipped or
// repeats the previous line causes no transfer. The csr port loads the text base,
// which becomes the starting address for the next advance.
// A request is taken only while the encoder is idle. An accepted record goes through
// setup, then emits its bytes in order: the advance bytes (up to 59, each taking
// 127 units off the shared subtractor; a final advance chunk that is empty emits
// nothing), then one or five line bytes. An advance above 7493 units gives one
// overflow-flagged byte.
// Reset clears the previous line, the table parity and the address reference.
// A single output register holds the pending byte; when the receiver stalls, the
// encoder waits and resumes as soon as that byte is taken.
`timescale 1ns / 1ps
module pc_line_table_encoder
   import pclte_pkg::*;
#(
   parameter int MIN_INSTR_BYTES = MIN_INSTR_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pclte_req_if.sink   req_ch,
   pclte_rsp_if.source rsp_ch,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int LIMIT = (MAX_UNITS + 1) * MIN_INSTR_BYTES;
   localparam int REM_W = $clog2(LIMIT);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_OVF  = 3'd2;
   localparam logic [2:0] ST_ADV  = 3'd3;
   localparam logic [2:0] ST_LINE = 3'd4;

   localparam logic [2:0] LAST_IDX = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] prev_pc_ff, prev_pc_in;
   logic [30:0] prev_line_ff, prev_line_in;
   logic        size_odd_ff, size_odd_in;
   logic [31:0] pc_ff, pc_in;
   logic [30:0] line_ff, line_in;
   logic [31:0] delta_ff, delta_in;
   logic        big_ff, big_in;
   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   logic              slot_free;
   logic              accept;
   logic              emit;
   logic [7:0]        emit_byte;
   logic              emit_last;
   logic              emit_ovf;
   logic              adv_load;
   logic              adv_step;
   logic [REM_W-1:0]  adv_load_val;
   adv_stat_type      adv_stat;
   logic              pc_ge;
   logic [31:0]       diff;
   logic [31:0]       delta;
   logic              delta_big;
   logic [7:0]        small_byte;
   logic [7:0]        line_byte;

   pclte_adv_unit #(
      .MIN_INSTR_BYTES (MIN_INSTR_BYTES),
      .REM_W           (REM_W)
   ) u_adv (
      .clock    (clock),
      .load     (adv_load),
      .load_val (adv_load_val),
      .step     (adv_step),
      .stat     (adv_stat)
   );

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept = req_ch.valid && req_ch.ready;

   assign pc_ge = (req_ch.pc >= prev_pc_ff);
   assign diff = req_ch.pc - prev_pc_ff;
   assign adv_load_val = pc_ge ? diff[REM_W-1:0] : '0;
   assign delta = {1'b0, req_ch.line} - {1'b0, prev_line_ff};
   assign delta_big = ($signed(delta) > 32'sd64) || ($signed(delta) < -32'sd64);

   assign small_byte = delta_ff[31] ? (8'(DOWN_BASE) - delta_ff[7:0]) : delta_ff[7:0];

   always_comb begin
      case (idx_ff)
         3'd0:    line_byte = 8'(LONG_MARK);
         3'd1:    line_byte = delta_ff[31:24];
         3'd2:    line_byte = delta_ff[23:16];
         3'd3:    line_byte = delta_ff[15:8];
         default: line_byte = delta_ff[7:0];
      endcase
      if (!big_ff) begin
         line_byte = small_byte;
      end
   end

   always_comb begin
      state_in     = state_ff;
      prev_pc_in   = prev_pc_ff;
      prev_line_in = prev_line_ff;
      pc_in        = pc_ff;
      line_in      = line_ff;
      delta_in     = delta_ff;
      big_in       = big_ff;
      idx_in       = idx_ff;
      adv_load     = 1'b0;
      adv_step     = 1'b0;
      emit         = 1'b0;
      emit_byte    = 8'(PAD_BYTE);
      emit_last    = 1'b0;
      emit_ovf     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.func) begin
                  if (size_odd_ff) begin
                     state_in = ST_PAD;
                  end
               end else if (!req_ch.skip && req_ch.line != prev_line_ff) begin
                  if (pc_ge && diff >= 32'(LIMIT)) begin
                     state_in = ST_OVF;
                  end else begin
                     adv_load = 1'b1;
                     pc_in    = req_ch.pc;
                     line_in  = req_ch.line;
                     delta_in = delta;
                     big_in   = delta_big;
                     idx_in   = '0;
                     state_in = ST_ADV;
                  end
               end
            end
         end
         ST_PAD: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = 8'(PAD_BYTE);
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_OVF: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = 8'(LONG_MARK);
               emit_last = 1'b1;
               emit_ovf  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_ADV: begin
            if (slot_free) begin
               if (adv_stat.big) begin
                  emit      = 1'b1;
                  emit_byte = 8'(ADV_BASE + UNITS_PER_BYTE);
                  adv_step  = 1'b1;
               end else begin
                  emit      = (adv_stat.units != '0);
                  emit_byte = 8'(ADV_BASE) + {1'b0, adv_stat.units};
                  state_in  = ST_LINE;
               end
            end
         end
         ST_LINE: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = line_byte;
               emit_last = !big_ff || idx_ff == LAST_IDX;
               idx_in    = idx_ff + 3'd1;
               if (emit_last) begin
                  prev_line_in = line_ff;
                  prev_pc_in   = pc_ff + 32'(MIN_INSTR_BYTES);
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         prev_pc_in = csr_wr_data;
      end
   end

   always_comb begin
      size_odd_in  = size_odd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
         rsp_ovf_in   = emit_ovf;
         if (!emit_ovf) begin
            size_odd_in = !size_odd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_pc_ff   <= '0;
         prev_line_ff <= '0;
         size_odd_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_pc_ff   <= prev_pc_in;
         prev_line_ff <= prev_line_in;
         size_odd_ff  <= size_odd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff       <= pc_in;
      line_ff     <= line_in;
      delta_ff    <= delta_in;
      big_ff      <= big_in;
      idx_ff      <= idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.last     = rsp_last_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

endmodule
